@@ rtl/core/mma_pkg.sv @@
package mma_pkg;

  // Filter dimensions.
  localparam int CHANNELS = 8;
  localparam int WINDOW   = 16;

  // Fixed field widths.
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 16;

  // Derived storage widths.
  localparam int CHS_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH  = CHANNELS * WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Running window sum and its magnitude.
  localparam int SUM_W = SAMPLE_W + POS_W + 1;
  localparam int MAG_W = SUM_W - 1;

  // Division by WINDOW as a multiplication by a rounded-up reciprocal.
  // The shift is wide enough that the error stays below 1/WINDOW for
  // every magnitude that fits in MAG_W bits, so the floor is exact.
  localparam int DIV_SHIFT = MAG_W + POS_W;
  localparam int RECIP_W   = SUM_W + 1;
  localparam longint unsigned DIV_RECIP_L =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(DIV_RECIP_L);
  localparam int PROD_W = MAG_W + RECIP_W;
  localparam int QUOT_W = PROD_W - DIV_SHIFT;

  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] average;
  } out_word_t;

endpackage

@@ rtl/core/multichannel_moving_average.sv @@
// Multichannel moving-average filter.
// Input channel: in_valid, in_stall and in_word carry a channel number and a
// signed 16-bit sample. Result channel: out_valid, out_stall and out_word
// carry the channel number and the truncated average of that channel's last
// WINDOW samples. Every input word yields exactly one result word, in order.
// A word passes through a read of the window memory, an update of the
// channel's running sum with the memory write-back, a reciprocal multiply
// and the output register. Only one word is in flight at a time: a new word
// is taken only once the last one has left the output stage, so the memory
// read at acceptance and the update, multiply and output sequence never overlap.
// After reset the block sweeps all CHANNELS * WINDOW entries (128 here) of the
// window memory to zero, one entry a cycle, and holds in_stall high meanwhile.
// Early averages therefore include zeros. A stalled result stays in the
// output register; the next word is still accepted and worked on, and it
// waits in the last stage until the output register is free.
module multichannel_moving_average (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mma_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output mma_pkg::out_word_t out_word
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [mma_pkg::ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic signed [mma_pkg::SUM_W-1:0] sum_r [mma_pkg::CHANNELS];
  logic [mma_pkg::POS_W-1:0]        pos_r [mma_pkg::CHANNELS];

  // Per-word registers.
  logic [mma_pkg::CH_W-1:0]            channel_r;
  logic signed [mma_pkg::SAMPLE_W-1:0] sample_r;
  logic                                ch_ok_r;
  logic [mma_pkg::ADDR_W-1:0]          addr_r;
  logic [mma_pkg::POS_W-1:0]           item_pos_r;
  logic [mma_pkg::MAG_W-1:0]           mag_r;
  logic                                neg_r;
  logic [mma_pkg::PROD_W-1:0]          prod_r;

  logic      out_valid_r, out_valid_nxt;
  mma_pkg::out_word_t out_word_r;

  logic                        accept;
  logic                        in_ch_ok;
  logic [mma_pkg::CHS_W-1:0]   in_idx;
  logic [mma_pkg::POS_W-1:0]   in_pos;
  logic [mma_pkg::ADDR_W-1:0]  in_addr;
  logic [mma_pkg::CHS_W-1:0]   cur_idx;
  logic signed [mma_pkg::SUM_W-1:0]    sum_cur, sum_new;
  logic [mma_pkg::SAMPLE_W-1:0]        ram_rdata;
  logic signed [mma_pkg::SAMPLE_W-1:0] old_sample;
  logic [mma_pkg::POS_W-1:0]           pos_next;
  logic [mma_pkg::SUM_W-1:0]           sum_neg;
  logic [mma_pkg::QUOT_W-1:0]          quot_full;
  logic [mma_pkg::SAMPLE_W-1:0]        quot;
  logic signed [mma_pkg::SAMPLE_W-1:0] avg;
  logic                                out_load;

  logic                       ram_we;
  logic [mma_pkg::ADDR_W-1:0] ram_waddr;
  logic [mma_pkg::SAMPLE_W-1:0] ram_wdata;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Address of the slot that the incoming sample replaces.
  always_comb begin
    in_ch_ok = (int'(in_word.channel) < mma_pkg::CHANNELS);
    in_idx   = mma_pkg::CHS_W'(in_word.channel);
    in_pos   = '0;
    if (in_ch_ok) begin
      in_pos = pos_r[in_idx];
    end
    in_addr = mma_pkg::ADDR_W'(int'(in_idx) * mma_pkg::WINDOW + int'(in_pos));
  end

  mma_ram #(
    .WIDTH (mma_pkg::SAMPLE_W),
    .DEPTH (mma_pkg::DEPTH)
  ) u_window_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && in_ch_ok),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  assign old_sample = ram_rdata;

  // Running sum update: drop the overwritten sample, add the new one.
  always_comb begin
    cur_idx = mma_pkg::CHS_W'(channel_r);
    sum_cur = '0;
    if (ch_ok_r) begin
      sum_cur = sum_r[cur_idx];
    end
    sum_new = sum_cur - mma_pkg::SUM_W'(old_sample) + mma_pkg::SUM_W'(sample_r);
    sum_neg = -sum_new;
    if (item_pos_r == mma_pkg::POS_W'(mma_pkg::WINDOW - 1)) begin
      pos_next = '0;
    end else begin
      pos_next = item_pos_r + 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = sample_r;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == ST_READ) begin
      ram_we = ch_ok_r;
    end
  end

  always_comb begin
    quot_full = prod_r[mma_pkg::PROD_W-1:mma_pkg::DIV_SHIFT];
    quot      = quot_full[mma_pkg::SAMPLE_W-1:0];
    avg       = neg_r ? -quot : quot;
  end

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == mma_pkg::ADDR_W'(mma_pkg::DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < mma_pkg::CHANNELS; c++) begin
        sum_r[c] <= '0;
        pos_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_READ && ch_ok_r) begin
        sum_r[cur_idx] <= sum_new;
        pos_r[cur_idx] <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      channel_r  <= in_word.channel;
      sample_r   <= in_word.sample;
      ch_ok_r    <= in_ch_ok;
      addr_r     <= in_addr;
      item_pos_r <= in_pos;
    end
    if (state_r == ST_READ) begin
      // An out-of-range channel averages to zero.
      neg_r <= ch_ok_r && sum_new[mma_pkg::SUM_W-1];
      if (!ch_ok_r) begin
        mag_r <= '0;
      end else if (sum_new[mma_pkg::SUM_W-1]) begin
        mag_r <= sum_neg[mma_pkg::MAG_W-1:0];
      end else begin
        mag_r <= sum_new[mma_pkg::MAG_W-1:0];
      end
    end
    if (state_r == ST_MUL) begin
      prod_r <= mma_pkg::PROD_W'(mag_r) * mma_pkg::PROD_W'(mma_pkg::DIV_RECIP);
    end
    if (out_load) begin
      out_word_r.out_channel <= channel_r;
      out_word_r.average     <= avg;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // An accepted word always moves on to the memory read stage.
  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_READ))
    else $error("accepted word did not enter the read stage");

  // The window memory is written only by the clearing sweep or a word update.
  a_ram_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR || state_r == ST_READ))
    else $error("window memory written outside clear or update");

  // The reciprocal quotient never exceeds the magnitude of a full-scale sample.
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |->
      (quot_full <= mma_pkg::QUOT_W'(1 << (mma_pkg::SAMPLE_W - 1))))
    else $error("average quotient out of range");

  // A positive average can never reach the negative full-scale code.
  a_quot_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && !neg_r) |->
      (quot_full < mma_pkg::QUOT_W'(1 << (mma_pkg::SAMPLE_W - 1))))
    else $error("positive average overflows");

  // The output stage only completes once the word has passed the multiplier.
  a_out_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> ($past(state_r) == ST_MUL || $past(state_r) == ST_OUT))
    else $error("result loaded without passing the multiplier");

endmodule

@@ rtl/core/mma_ram.sv @@
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
